[sv/spc_pkg.sv]
// Shared types, constants and the CRC-16 byte update for the status packet checker.
package spc_pkg;

    localparam int COUNT_W = 17;

    typedef logic [COUNT_W-1:0] count_t;

    // Result status codes, first failing check wins
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_BAD_HDR   = 3'd2,
        ST_BAD_LEN   = 3'd3,
        ST_BAD_CRC   = 3'd4,
        ST_DEV_ERROR = 3'd5
    } status_t;

    localparam logic [15:0] CRC_POLY     = 16'h8005;
    localparam logic [7:0]  HDR_SYNC     = 8'hFF;
    localparam logic [7:0]  HDR_PROTO    = 8'hFD;
    localparam logic [7:0]  HDR_RSVD     = 8'h00;
    localparam count_t      MIN_PACKET   = count_t'(11);
    localparam count_t      LEN_OVERHEAD = count_t'(7);
    localparam count_t      COUNT_MAX    = '1;
    localparam count_t      CRC_START    = count_t'(2);

    // Byte offsets within a reply packet
    localparam count_t OFS_SYNC0  = count_t'(0);
    localparam count_t OFS_SYNC1  = count_t'(1);
    localparam count_t OFS_PROTO  = count_t'(2);
    localparam count_t OFS_RSVD   = count_t'(3);
    localparam count_t OFS_ID     = count_t'(4);
    localparam count_t OFS_LEN_LO = count_t'(5);
    localparam count_t OFS_LEN_HI = count_t'(6);
    localparam count_t OFS_ERR    = count_t'(8);
    localparam count_t OFS_VAL_LO = count_t'(9);
    localparam count_t OFS_VAL_HI = count_t'(10);

    // MSB-first CRC-16 over one byte, no reflection
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

[sv/spc_byte_if.sv]
// Byte channel: one received reply byte per word, with a last-byte flag.
interface spc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       last_byte;

    modport source (output valid, output rx_byte, output last_byte, input ready);
    modport sink   (input valid, input rx_byte, input last_byte, output ready);
endinterface

[sv/spc_result_if.sv]
// Result channel: one status word per checked packet.
interface spc_result_if import spc_pkg::*; ();
    logic        valid;
    logic        ready;
    status_t     status;
    logic [7:0]  device_error;
    logic [7:0]  responder_id;
    logic [15:0] reply_value;

    modport source (output valid, output status, output device_error,
                    output responder_id, output reply_value, input ready);
    modport sink   (input valid, input status, input device_error,
                    input responder_id, input reply_value, output ready);
endinterface

[sv/status_packet_checker.sv]
// Top level: servo reply packet checker with header, length and CRC-16 checks.
//
// Usage
//   byte_stream : one reply byte per word, last_byte set on the final byte.
//   result      : one word per packet, issued for the byte flagged last.
//   Bytes go into an input register; the next stage updates the packet state
//   (count, header flag, id, length, error, value, CRC and a two-byte tail)
//   and, for a last byte, loads the status into the result register.
// Throughput: one byte per cycle, except while a last byte waits on an
//   unread result; the CRC-16 byte update is combinational (eight XOR steps
//   on the 16-bit accumulator).
// Status: 0 ok, 1 short (<11 bytes), 2 bad header, 3 bad length
//   (length + 7 != count), 4 bad CRC (low byte first), 5 device error.
//   The byte counter saturates, so an overlong packet reports bad length.
// Stall: a result waits in the result register until taken. Ordinary bytes
//   keep flowing meanwhile; only a last byte waits in the input register
//   while the previous result is still unread, and then ready drops.
// Reset: all packet state returns to its empty-packet values, both
//   registers empty. State also returns to those values after each result.
module status_packet_checker import spc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    spc_byte_if.sink     byte_stream,
    spc_result_if.source result
);

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // Packet state
    count_t      byte_count_reg,  byte_count_next;
    logic [15:0] crc_reg,         crc_next;
    logic [7:0]  tail0_reg,       tail0_next;
    logic [7:0]  tail1_reg,       tail1_next;
    logic        header_good_reg, header_good_next;
    logic [15:0] length_reg,      length_next;
    logic [7:0]  error_reg,       error_next;
    logic [7:0]  id_reg,          id_next;
    logic [15:0] value_reg,       value_next;

    // Result register
    logic        out_valid_reg;
    status_t     status_reg;
    logic [7:0]  dev_error_reg;
    logic [7:0]  resp_id_reg;
    logic [15:0] reply_value_reg;

    status_t     status_next;
    logic        step;
    logic        emit;
    count_t      length_total;
    logic [15:0] checksum;

    // A byte moves on unless it is last and the result slot is still full
    assign step = in_valid_reg && (!in_last_reg || !out_valid_reg || result.ready);
    assign emit = step && in_last_reg;

    assign byte_stream.ready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (byte_stream.ready)
        begin
            in_valid_reg <= byte_stream.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_stream.valid && byte_stream.ready)
        begin
            in_byte_reg <= byte_stream.rx_byte;
            in_last_reg <= byte_stream.last_byte;
        end
    end

    // Per-byte state update
    always_comb
    begin
        crc_next         = crc_reg;
        tail1_next       = tail0_reg;
        tail0_next       = in_byte_reg;
        header_good_next = header_good_reg;
        length_next      = length_reg;
        error_next       = error_reg;
        id_next          = id_reg;
        value_next       = value_reg;

        // oldest tail byte drops into the CRC once the delay line is full
        if (byte_count_reg >= CRC_START)
            crc_next = crc16_byte(crc_reg, tail1_reg);

        case (byte_count_reg) inside
            OFS_SYNC0, OFS_SYNC1:
                if (in_byte_reg != HDR_SYNC) header_good_next = 1'b0;
            OFS_PROTO:
                if (in_byte_reg != HDR_PROTO) header_good_next = 1'b0;
            OFS_RSVD:
                if (in_byte_reg != HDR_RSVD) header_good_next = 1'b0;
            OFS_ID:     id_next           = in_byte_reg;
            OFS_LEN_LO: length_next[7:0]  = in_byte_reg;
            OFS_LEN_HI: length_next[15:8] = in_byte_reg;
            OFS_ERR:    error_next        = in_byte_reg;
            OFS_VAL_LO: value_next[7:0]   = in_byte_reg;
            OFS_VAL_HI: value_next[15:8]  = in_byte_reg;
            default: ;
        endcase

        if (byte_count_reg != COUNT_MAX)
            byte_count_next = byte_count_reg + count_t'(1);
        else
            byte_count_next = byte_count_reg;
    end

    // Status for the packet ending with this byte
    assign length_total = count_t'(length_next) + LEN_OVERHEAD;
    assign checksum     = {in_byte_reg, tail0_reg};

    always_comb
    begin
        if (byte_count_next < MIN_PACKET)
            status_next = ST_SHORT;
        else if (!header_good_next)
            status_next = ST_BAD_HDR;
        else if (length_total != byte_count_next)
            status_next = ST_BAD_LEN;
        else if (crc_next != checksum)
            status_next = ST_BAD_CRC;
        else if (error_next != 8'h00)
            status_next = ST_DEV_ERROR;
        else
            status_next = ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg  <= '0;
            crc_reg         <= '0;
            tail0_reg       <= '0;
            tail1_reg       <= '0;
            header_good_reg <= 1'b1;
            length_reg      <= '0;
            error_reg       <= '0;
            id_reg          <= '0;
            value_reg       <= '0;
        end
        else if (emit)
        begin
            // packet done: back to empty-packet values
            byte_count_reg  <= '0;
            crc_reg         <= '0;
            tail0_reg       <= '0;
            tail1_reg       <= '0;
            header_good_reg <= 1'b1;
            length_reg      <= '0;
            error_reg       <= '0;
            id_reg          <= '0;
            value_reg       <= '0;
        end
        else if (step)
        begin
            byte_count_reg  <= byte_count_next;
            crc_reg         <= crc_next;
            tail0_reg       <= tail0_next;
            tail1_reg       <= tail1_next;
            header_good_reg <= header_good_next;
            length_reg      <= length_next;
            error_reg       <= error_next;
            id_reg          <= id_next;
            value_reg       <= value_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            status_reg      <= status_next;
            dev_error_reg   <= error_next;
            resp_id_reg     <= id_next;
            reply_value_reg <= value_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.status       = status_reg;
    assign result.device_error = dev_error_reg;
    assign result.responder_id = resp_id_reg;
    assign result.reply_value  = reply_value_reg;

endmodule

[sv/spc_checker.sv]
// Port-level assertions for the status packet checker, bound to the top level.
module spc_checker import spc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        byte_ready,
    input logic        res_valid,
    input logic        res_ready,
    input status_t     res_status,
    input logic [7:0]  res_device_error
);

    // A stalled result word holds its status
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_status))
        else $error("result word changed while stalled");

    // Status codes stay within the defined set
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_status <= ST_DEV_ERROR)
        else $error("undefined status code");

    // An ok status means the device reported no error
    a_ok_no_error: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_status == ST_OK |-> res_device_error == 8'h00)
        else $error("ok status with nonzero device error");

    // With the result slot empty the byte side never stalls
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> byte_ready)
        else $error("byte side stalled with empty result slot");

    // Result slot is empty right after reset
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !res_valid)
        else $error("result valid out of reset");

endmodule

bind status_packet_checker spc_checker u_spc_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .byte_ready       (byte_stream.ready),
    .res_valid        (result.valid),
    .res_ready        (result.ready),
    .res_status       (result.status),
    .res_device_error (result.device_error)
);
